// ===== rtl/core/hnd_pkg.sv =====
`default_nettype none

package hnd_pkg;

	// Field widths
	localparam int unsigned XW = 10;
	localparam int unsigned WW = 20;
	localparam int unsigned DW = 10;
	localparam int unsigned YW = 23;

	// Lanes that have an input field on the stream
	localparam int unsigned X_FIELDS = 8;
	localparam int unsigned NUM_INPUTS_DEF = 8;

	localparam int unsigned TDATA_IN_W = 80;
	localparam int unsigned TDATA_OUT_W = 24;

	localparam logic [WW-1:0] W_MAX = 20'd1048575;
	localparam logic [YW-1:0] Y_MAX = 23'd8388607;
	localparam logic [WW-1:0] W_RESET = 20'd1000;

	// Division by 1000 is done as a shift right by 3 and then a multiply by
	// ceil(2^38/125); the result is exact for dividends below 2^34.
	localparam int unsigned DIV_PRE = 3;
	localparam int unsigned RECIP_SH = 38;
	localparam logic [31:0] RECIP_M = 32'd2199023256;

	// Width of one lane quotient x*w/1000
	localparam int unsigned QW = 21;

	// Configuration register indexes
	localparam logic [1:0] REG_INIT_WEIGHT = 2'd0;
	localparam logic [1:0] REG_LOW_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_DECAY_LOW = 2'd2;
	localparam logic [1:0] REG_DECAY_HIGH = 2'd3;

	localparam logic [0:0] KIND_LEARN = 1'b0;

	typedef struct packed {
		logic [WW-1:0] init_weight;
		logic [WW-1:0] low_weight_threshold;
		logic [DW-1:0] decay_low;
		logic [DW-1:0] decay_high;
	} cfg_t;

	typedef struct packed {
		logic wr_en;
		logic reinit;
	} lane_ctrl_t;

	typedef struct packed {
		logic [QW-1:0] quo;
		logic          sat;
	} lane_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WRITE
	} state_t;

	localparam logic [2:0] CALC_LAST = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/hebbian_neuron_with_decay.sv =====
`default_nettype none

// Hebbian neuron with weight decay. Each word on the input stream carries
// eight inputs in tdata and a kind bit in tuser: a learn word returns the
// saturated sum of x*w/1000 over the inputs and the current weights and then
// updates every weight by (w*decay + x*y)/1000, clamped at 1048575; a reinit
// word loads every weight with init_weight and returns zero. Every word gives
// exactly one output word. The block takes no new word until it is through
// with the last one; a learn word passes through the lane chain of multiply,
// reciprocal multiply for the divide by 1000, lane sum, update multiply and
// second reciprocal multiply. The output register may hold a finished word
// while the block works on the next one; the block waits before writing the
// weights only if that register is still full. The user must write the APB
// configuration only while the block is idle; the block does not enforce it.
module hebbian_neuron_with_decay
	import hnd_pkg::*;
#(
	parameter int unsigned NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // x0, x1, ... x7 (10 bits each)
	input  wire logic                   s_tuser,   // kind
	// Output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [TDATA_OUT_W-1:0]      m_tdata,   // neuron_output (23 bits), zero pad
	output logic                        m_tuser,   // weight_saturated
	// Configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [3:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	cfg_t cfg_q;
	state_t state_q, state_d;
	logic [2:0] cnt_q;
	logic kind_q;
	logic [XW-1:0] x_q [NUM_INPUTS];
	logic [YW-1:0] y;
	logic sat_any;
	lane_res_t res [NUM_INPUTS];
	lane_ctrl_t ctrl;
	logic in_acc;
	logic out_load;
	logic out_valid_q;
	logic [YW-1:0] out_y_q;
	logic out_sat_q;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_weight <= 20'd1000;
			cfg_q.low_weight_threshold <= 20'd500;
			cfg_q.decay_low <= 10'd990;
			cfg_q.decay_high <= 10'd999;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_INIT_WEIGHT: cfg_q.init_weight <= pwdata[WW-1:0];
				REG_LOW_THRESHOLD: cfg_q.low_weight_threshold <= pwdata[WW-1:0];
				REG_DECAY_LOW: cfg_q.decay_low <= pwdata[DW-1:0];
				REG_DECAY_HIGH: cfg_q.decay_high <= pwdata[DW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_INIT_WEIGHT: prdata = 32'(cfg_q.init_weight);
			REG_LOW_THRESHOLD: prdata = 32'(cfg_q.low_weight_threshold);
			REG_DECAY_LOW: prdata = 32'(cfg_q.decay_low);
			REG_DECAY_HIGH: prdata = 32'(cfg_q.decay_high);
			default: prdata = '0;
		endcase
	end

	// Input capture
	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= s_tuser;
		end
	end

	for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_x
		if (i < X_FIELDS) begin : g_field
			always_ff @(posedge clk) begin
				if (in_acc) begin
					x_q[i] <= s_tdata[i*XW +: XW];
				end
			end
		end else begin : g_zero
			assign x_q[i] = '0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_q == ST_CALC) ? cnt_q + 3'd1 : 3'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == KIND_LEARN) ? ST_CALC : ST_WRITE;
				end
			end
			ST_CALC: begin
				if (cnt_q == CALC_LAST) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					ctrl.wr_en = (kind_q == KIND_LEARN);
					ctrl.reinit = (kind_q != KIND_LEARN);
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Lanes and merge
	for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
		hnd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.x      (x_q[i]),
			.y      (y),
			.cfg    (cfg_q),
			.ctrl   (ctrl),
			.res    (res[i])
		);
	end

	hnd_merge #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_merge (
		.clk     (clk),
		.res     (res),
		.y       (y),
		.sat_any (sat_any)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_y_q <= (kind_q == KIND_LEARN) ? y : '0;
			out_sat_q <= (kind_q == KIND_LEARN) ? sat_any : 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = TDATA_OUT_W'(out_y_q);
	assign m_tuser = out_sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/hnd_lane.sv =====
`default_nettype none

module hnd_lane
	import hnd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [XW-1:0] x,
	input  wire logic [YW-1:0] y,
	input  cfg_t            cfg,
	input  lane_ctrl_t      ctrl,
	output lane_res_t       res
);

	logic [WW-1:0] w_q;
	logic [2*WW-11:0] prod_s1;
	logic [WW+DW-1:0] wd_s1;
	logic [58:0] recip_s2;
	logic [33:0] upd_s4;
	logic [62:0] recip2_s5;
	logic [DW-1:0] decay;
	logic [24:0] nw;
	logic [WW-1:0] nw_clamped;
	logic nw_sat;

	assign decay = (w_q < cfg.low_weight_threshold) ? cfg.decay_low : cfg.decay_high;

	// The registers below run every cycle; the sequencer holds x and the
	// weight steady, so each stage settles to the value of the current word.
	always_ff @(posedge clk) begin
		prod_s1   <= 30'(x) * 30'(w_q);
		wd_s1     <= 30'(w_q) * 30'(decay);
		recip_s2  <= 59'(prod_s1[29:DIV_PRE]) * 59'(RECIP_M);
		upd_s4    <= 34'(wd_s1) + 34'(x) * 34'(y);
		recip2_s5 <= 63'(upd_s4[33:DIV_PRE]) * 63'(RECIP_M);
	end

	assign nw = recip2_s5[62:RECIP_SH];
	assign nw_sat = (nw > 25'(W_MAX));
	assign nw_clamped = nw_sat ? W_MAX : nw[WW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RESET;
		end else if (ctrl.reinit) begin
			w_q <= cfg.init_weight;
		end else if (ctrl.wr_en) begin
			w_q <= nw_clamped;
		end
	end

	assign res.quo = recip_s2[58:RECIP_SH];
	assign res.sat = nw_sat;

endmodule

`default_nettype wire

// ===== rtl/core/hnd_merge.sv =====
`default_nettype none

module hnd_merge
	import hnd_pkg::*;
#(
	parameter int unsigned NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  wire logic      clk,
	input  lane_res_t      res [NUM_INPUTS],
	output logic [YW-1:0]  y,
	output logic           sat_any
);

	localparam int unsigned SW = QW + $clog2(NUM_INPUTS);

	logic [SW-1:0] sum;
	logic [YW-1:0] y_s3;

	always_comb begin
		sum = '0;
		sat_any = 1'b0;
		for (int i = 0; i < NUM_INPUTS; i++) begin
			sum = sum + SW'(res[i].quo);
			sat_any = sat_any | res[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		y_s3 <= (sum > SW'(Y_MAX)) ? Y_MAX : sum[YW-1:0];
	end

	assign y = y_s3;

endmodule

`default_nettype wire
